### sv/fbt_pkg.sv
// Shared definitions for the page-mode frame store text plotter.
// Holds command codes, sequencer control and status structs, and the 5x7 font table.
// No dependencies; the sequencer, datapath and top level refer to it by scoped names.
package fbt_pkg;

  localparam int DISP_WIDTH_DEF  = 128;
  localparam int DISP_HEIGHT_DEF = 64;

  // Printable range covered by the font table.
  localparam logic [7:0] FIRST_CODE = 8'd32;
  localparam logic [7:0] LAST_CODE  = 8'd126;
  localparam int GLYPH_COUNT = 95;

  // A character cell is 5 columns by 8 rows.
  localparam int CELL_PIXELS = 40;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_PLOT  = 2'd1,
    CMD_CHAR  = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  // One control word's worth of datapath strobes.
  typedef struct packed {
    logic accept;    // input channel may take a beat
    logic mem_clr;   // write zero at the sweep counter and advance it
    logic run;       // issue the pixel at the counter and advance it
    logic rd_issue;  // read the byte named by the latched index
    logic out_load;  // load the result register when it is free
  } ctrl_t;

  // Datapath conditions the sequencer branches on.
  typedef struct packed {
    logic in_fire;
    cmd_t cmd;
    logic code_ok;
    logic last;
    logic out_free;
  } status_t;

  // Each entry packs the five font columns with column 0 in the low byte,
  // so bit (col * 8 + row) is the cell pixel at that column and row.
  localparam logic [39:0] GLYPH_ROM [GLYPH_COUNT] = '{
    40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14, 40'h122A7F2A24,
    40'h6264081323, 40'h5022554936, 40'h0000030500, 40'h0041221C00, 40'h001C224100,
    40'h14083E0814, 40'h08083E0808, 40'h0000305000, 40'h0808080808, 40'h0000606000,
    40'h0204081020, 40'h3E4549513E, 40'h00407F4200, 40'h4649494972, 40'h334D494121,
    40'h107F121418, 40'h3945454527, 40'h3149494A3C, 40'h0709112141, 40'h3649494936,
    40'h1E29494946, 40'h0000363600, 40'h0000365600, 40'h0041221408, 40'h1414141414,
    40'h0814224100, 40'h0609590102, 40'h4E595D413E, 40'h7C1211127C, 40'h364949497F,
    40'h224141413E, 40'h1C2241417F, 40'h414949497F, 40'h010909097F, 40'h7A4949413E,
    40'h7F0808087F, 40'h00417F4100, 40'h013F414020, 40'h412214087F, 40'h404040407F,
    40'h7F020C027F, 40'h7F1008047F, 40'h3E4141413E, 40'h060909097F, 40'h5E2151413E,
    40'h462919097F, 40'h3149494946, 40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F,
    40'h3F4038403F, 40'h6314081463, 40'h0708700807, 40'h4345495161, 40'h0041417F00,
    40'h2010080402, 40'h007F414100, 40'h0402010204, 40'h4040404040, 40'h0004020100,
    40'h7854545420, 40'h384444487F, 40'h2044444438, 40'h7F48444438, 40'h1854545438,
    40'h0201097E08, 40'h3E5252520C, 40'h780404087F, 40'h00407D4400, 40'h003D444020,
    40'h004428107F, 40'h00407F4100, 40'h780418047C, 40'h780404087C, 40'h3844444438,
    40'h081414147C, 40'h7C18141408, 40'h080404087C, 40'h2054545448, 40'h2040443F04,
    40'h7C2040403C, 40'h1C2040201C, 40'h3C4030403C, 40'h4428102844, 40'h3C5050500C,
    40'h444C546444, 40'h0041360800, 40'h00007F0000, 40'h0008364100, 40'h081C2A0808
  };

endpackage

### sv/fbt_sequencer.sv
// Microcode sequencer: step register, read-only program table and jump logic.
// Depends on fbt_pkg for the control and status structs and command codes.
module fbt_sequencer (
  input  logic             clk,
  input  logic             rst_n,
  input  fbt_pkg::status_t status,
  output fbt_pkg::ctrl_t   ctrl
);

  typedef enum logic [2:0] {
    ST_RSTCLR,
    ST_IDLE,
    ST_CLR,
    ST_RD,
    ST_RUN,
    ST_DRAIN,
    ST_FIN
  } step_t;

  typedef enum logic [1:0] {
    J_GOTO,
    J_WAIT,
    J_DISPATCH
  } jump_t;

  typedef enum logic [1:0] {
    C_NONE,
    C_LAST,
    C_OUT_FREE
  } cond_t;

  typedef struct packed {
    fbt_pkg::ctrl_t ctrl;
    jump_t          jump;
    cond_t          cond;
    step_t          target;
  } uword_t;

  // The program. A waiting step repeats until its condition holds.
  function automatic uword_t ucode(step_t s);
    uword_t w;
    w = '0;
    case (s)
      ST_RSTCLR: begin
        w.ctrl.mem_clr = 1'b1;
        w.jump         = J_WAIT;
        w.cond         = C_LAST;
        w.target       = ST_IDLE;
      end
      ST_IDLE: begin
        w.ctrl.accept = 1'b1;
        w.jump        = J_DISPATCH;
      end
      ST_CLR: begin
        w.ctrl.mem_clr = 1'b1;
        w.jump         = J_WAIT;
        w.cond         = C_LAST;
        w.target       = ST_FIN;
      end
      ST_RD: begin
        w.ctrl.rd_issue = 1'b1;
        w.jump          = J_GOTO;
        w.target        = ST_FIN;
      end
      ST_RUN: begin
        w.ctrl.run = 1'b1;
        w.jump     = J_WAIT;
        w.cond     = C_LAST;
        w.target   = ST_DRAIN;
      end
      ST_DRAIN: begin
        w.jump   = J_GOTO;
        w.target = ST_FIN;
      end
      ST_FIN: begin
        w.ctrl.out_load = 1'b1;
        w.jump          = J_WAIT;
        w.cond          = C_OUT_FREE;
        w.target        = ST_IDLE;
      end
      default: begin
        w.jump   = J_GOTO;
        w.target = ST_IDLE;
      end
    endcase
    return w;
  endfunction

  step_t  step_r, step_nxt;
  uword_t uw;
  logic   cond_hit;

  always_comb begin
    uw   = ucode(step_r);
    ctrl = uw.ctrl;

    case (uw.cond)
      C_LAST:     cond_hit = status.last;
      C_OUT_FREE: cond_hit = status.out_free;
      default:    cond_hit = 1'b1;
    endcase

    case (uw.jump)
      J_GOTO: step_nxt = uw.target;
      J_WAIT: step_nxt = cond_hit ? uw.target : step_r;
      J_DISPATCH: begin
        if (status.in_fire) begin
          case (status.cmd)
            fbt_pkg::CMD_CLEAR: step_nxt = ST_CLR;
            fbt_pkg::CMD_PLOT:  step_nxt = ST_RUN;
            fbt_pkg::CMD_CHAR:  step_nxt = status.code_ok ? ST_RUN : ST_FIN;
            fbt_pkg::CMD_READ:  step_nxt = ST_RD;
            default:            step_nxt = ST_FIN;
          endcase
        end else begin
          step_nxt = step_r;
        end
      end
      default: step_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_RSTCLR;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

### sv/fbt_datapath.sv
// Datapath: command latches, pixel address unit, frame store memory with a
// one-deep write forward, and the result register. Driven by fbt_sequencer.
// Depends on fbt_pkg.
module fbt_datapath #(
  parameter int DISP_WIDTH  = fbt_pkg::DISP_WIDTH_DEF,
  parameter int DISP_HEIGHT = fbt_pkg::DISP_HEIGHT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_cmd,
  input  logic signed [9:0]  in_pos_x,
  input  logic signed [9:0]  in_pos_y,
  input  logic [7:0]         in_char_code,
  input  logic               in_ink,
  input  logic [9:0]         in_byte_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_read_data,
  input  fbt_pkg::ctrl_t     ctrl,
  output fbt_pkg::status_t   status
);

  localparam int PAGES       = (DISP_HEIGHT + 7) / 8;
  localparam int STORE_BYTES = DISP_WIDTH * PAGES;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int CNT_W       = (ADDR_W > 6) ? ADDR_W : 6;

  logic [7:0] mem [STORE_BYTES];

  logic in_fire, code_ok, out_free, last;
  logic [6:0] glyph_idx;

  logic [9:0]        x_r, y_r;
  logic              ink_r, pix_mode_r, rd_cmd_r, idx_ok_r;
  logic [ADDR_W-1:0] idx_r;
  logic [39:0]       glyph_r;

  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  logic [2:0]        col, row;
  logic [10:0]       px, py;
  logic              on_disp, pix_val;
  logic [ADDR_W-1:0] pix_addr;

  logic              pend_r, wval_r;
  logic [ADDR_W-1:0] wa_r;
  logic [2:0]        wbit_r;
  logic              fwd_v_r;
  logic [ADDR_W-1:0] fwd_a_r;
  logic [7:0]        fwd_d_r;
  logic [7:0]        rdata_r, base, merged;

  logic              mem_we, mem_rd;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [7:0]        wdata;

  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_data_r;

  assign in_fire  = in_valid && ctrl.accept;
  assign in_stall = !ctrl.accept;
  assign code_ok  = (in_char_code >= fbt_pkg::FIRST_CODE) &&
                    (in_char_code <= fbt_pkg::LAST_CODE);
  assign glyph_idx = 7'(in_char_code - fbt_pkg::FIRST_CODE);
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    if (ctrl.mem_clr) begin
      last = (cnt_r == CNT_W'(STORE_BYTES - 1));
    end else if (pix_mode_r) begin
      last = (cnt_r == '0);
    end else begin
      last = (cnt_r == CNT_W'(fbt_pkg::CELL_PIXELS - 1));
    end
  end

  assign status.in_fire  = in_fire;
  assign status.cmd      = fbt_pkg::cmd_t'(in_cmd);
  assign status.code_ok  = code_ok;
  assign status.last     = last;
  assign status.out_free = out_free;

  // Pixel at the counter. A lone plotted pixel sits at offset zero.
  always_comb begin
    col = pix_mode_r ? 3'd0 : cnt_r[5:3];
    row = pix_mode_r ? 3'd0 : cnt_r[2:0];
    px  = {x_r[9], x_r} + {8'd0, col};
    py  = {y_r[9], y_r} + {8'd0, row};
    on_disp = !px[10] && (px < 11'(DISP_WIDTH)) && !py[10] && (py < 11'(DISP_HEIGHT));
    pix_addr = ADDR_W'(12'(py[5:3]) * 12'(DISP_WIDTH) + 12'(px[7:0]));
    pix_val  = pix_mode_r ? ink_r : (glyph_r[cnt_r[5:0]] ? ink_r : !ink_r);
  end

  // The byte read for a pixel comes back in the next cycle; if the previous
  // pixel wrote the same byte on the edge of that read, its new value is taken instead.
  always_comb begin
    base   = (fwd_v_r && (fwd_a_r == wa_r)) ? fwd_d_r : rdata_r;
    merged = wval_r ? (base | (8'd1 << wbit_r)) : (base & ~(8'd1 << wbit_r));
    mem_we = pend_r || ctrl.mem_clr;
    waddr  = ctrl.mem_clr ? cnt_r[ADDR_W-1:0] : wa_r;
    wdata  = ctrl.mem_clr ? 8'd0 : merged;
    mem_rd = (ctrl.run && on_disp) || (ctrl.rd_issue && idx_ok_r);
    raddr  = ctrl.run ? pix_addr : idx_r;
  end

  always_comb begin
    if (ctrl.mem_clr || ctrl.run) begin
      cnt_nxt = last ? '0 : cnt_r + CNT_W'(1);
    end else begin
      cnt_nxt = cnt_r;
    end
    if (ctrl.out_load && out_free) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (mem_rd) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      fwd_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      pend_r      <= ctrl.run && on_disp;
      fwd_v_r     <= pend_r;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      x_r        <= in_pos_x;
      y_r        <= in_pos_y;
      ink_r      <= in_ink;
      pix_mode_r <= (in_cmd == fbt_pkg::CMD_PLOT);
      rd_cmd_r   <= (in_cmd == fbt_pkg::CMD_READ);
      idx_ok_r   <= (12'(in_byte_index) < 12'(STORE_BYTES));
      idx_r      <= ADDR_W'(in_byte_index);
      glyph_r    <= code_ok ? fbt_pkg::GLYPH_ROM[glyph_idx] : 40'd0;
    end
    if (ctrl.run) begin
      wa_r   <= pix_addr;
      wbit_r <= py[2:0];
      wval_r <= pix_val;
    end
    if (pend_r) begin
      fwd_a_r <= wa_r;
      fwd_d_r <= merged;
    end
    if (ctrl.out_load && out_free) begin
      out_data_r <= (rd_cmd_r && idx_ok_r) ? rdata_r : 8'd0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;

endmodule

### sv/mono_framebuffer_text_plotter.sv
// Top level of the page-mode monochrome frame store with pixel and text plotting.
// Instantiates fbt_sequencer and fbt_datapath; depends on fbt_pkg.
//
// The block holds a DISP_WIDTH by DISP_HEIGHT monochrome frame store arranged
// in 8-row pages, one byte per column per page, with bit (row mod 8) being the
// pixel. Each input beat carries one command and produces exactly one result
// beat: a clear, a clipped pixel plot, a 5x8 character cell drawn from the
// built-in 5x7 font (set font bits take the ink value, clear bits its
// inverse, every pixel clipped on its own, codes outside 32 to 126 ignored),
// or a read of one store byte by index. Only the read returns data; every
// other command returns zero, as does a read beyond the store. Work is one
// command at a time, run by a small microcode program over a single-port
// read, single-port write frame store. A character runs one read-modify-write
// pixel per cycle through the memory, with the byte just written forwarded to
// the next pixel, and a clear sweeps the memory one byte per cycle. After reset
// the same sweep of all STORE_BYTES bytes (1024 at the default size) runs with
// in_stall held high. A new command can be accepted while the previous result
// beat still waits in the output register.
module mono_framebuffer_text_plotter #(
  parameter int DISP_WIDTH  = fbt_pkg::DISP_WIDTH_DEF,
  parameter int DISP_HEIGHT = fbt_pkg::DISP_HEIGHT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_cmd,
  input  logic signed [9:0] in_pos_x,
  input  logic signed [9:0] in_pos_y,
  input  logic [7:0]        in_char_code,
  input  logic              in_ink,
  input  logic [9:0]        in_byte_index,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_read_data
);

  // Control strobes flow from the program to the datapath; branch conditions
  // flow back.
  fbt_pkg::ctrl_t   ctrl;
  fbt_pkg::status_t status;

  fbt_sequencer u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctrl   (ctrl)
  );

  fbt_datapath #(
    .DISP_WIDTH  (DISP_WIDTH),
    .DISP_HEIGHT (DISP_HEIGHT)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cmd        (in_cmd),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .in_char_code  (in_char_code),
    .in_ink        (in_ink),
    .in_byte_index (in_byte_index),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_read_data (out_read_data),
    .ctrl          (ctrl),
    .status        (status)
  );

endmodule

### sv/fbt_checker.sv
// Port-level checks for mono_framebuffer_text_plotter, attached with bind.
// Depends only on the top level's port names.
module fbt_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_read_data
);

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_read_data))
    else $error("result beat changed while stalled");

  // The store sweep after reset keeps the input closed.
  a_reset_stall: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input open right after reset");

  // One command at a time: the input closes after every accepted beat.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second beat accepted back to back");

  // No result can appear in the cycle right after a command is taken.
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result appeared too early");

  // A result is only loaded while the block is busy with a command.
  a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result loaded while input was open");

endmodule

bind mono_framebuffer_text_plotter fbt_checker u_fbt_checker (.*);
